// ----- rtl/core/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_dp and sorted_priority_queue_unit; depends on nothing.
package spq_pkg;

  // Default queue depth and fixed field widths
  localparam int SpqDepthDef = 16;
  localparam int ValueW      = 32;
  localparam int KindW       = 2;
  localparam int PosW        = 4;
  localparam int CountW      = 5;

  // Operation codes carried on in_kind
  localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindW-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KindW-1:0] KIND_FIND   = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the incoming beat
    logic compare;  // register the parallel compare vectors
    logic update;   // shift the entries and register the result
  } spq_cmd_t;

endpackage

// ----- rtl/core/sorted_priority_queue_unit.sv -----
// Sorted priority queue: up to DEPTH signed values kept in ascending order.
// An accepted beat is captured, compared in the compare state and then shifted
// into the entry array in the update state, which loads the result registers.
// A new item can be accepted during the update of the previous one but not
// during its compare, on the shared entry array; the receiver cannot stall.
// Reset clears the entry count and the strobe; entries are not cleared.
// Depends on spq_pkg, spq_ctrl and spq_dp.
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = SpqDepthDef
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [KindW-1:0]         in_kind,
  input  logic signed [ValueW-1:0] in_value,
  output logic                     out_strobe,
  output logic                     out_ok,
  output logic [PosW-1:0]          out_position,
  output logic [CountW-1:0]        out_entry_count,
  output logic                     out_head_valid,
  output logic signed [ValueW-1:0] out_head_value
);

  spq_cmd_t cmd;

  // Sequence the compare and update cycles
  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the entries and produce results
  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_position    (out_position),
    .out_entry_count (out_entry_count),
    .out_head_valid  (out_head_valid),
    .out_head_value  (out_head_value)
  );

  // Every accepted beat gives its result beat
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("result strobe missing three cycles after accept");

  // Results never come in consecutive cycles
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe high in consecutive cycles");

  // Busy covers only the compare cycle
  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // A failed operation reports position zero
  a_fail_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_ok) |-> (out_position == '0))
    else $error("nonzero position on failed operation");

endmodule

// ----- rtl/core/spq_ctrl.sv -----
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg for the command struct.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output spq_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   cmp_r;
  logic   upd_r;
  logic   accept;

  // Take a beat when idle or while finishing the previous item
  assign accept = start & ~busy_r;

  // Hold state and registered commands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
      cmp_r   <= 1'b0;
      upd_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_CMP;
            busy_r  <= 1'b1;
            cmp_r   <= 1'b1;
          end
        end
        ST_CMP: begin
          state_r <= ST_UPD;
          busy_r  <= 1'b0;
          cmp_r   <= 1'b0;
          upd_r   <= 1'b1;
        end
        ST_UPD: begin
          upd_r <= 1'b0;
          if (accept) begin
            state_r <= ST_CMP;
            busy_r  <= 1'b1;
            cmp_r   <= 1'b1;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
          cmp_r   <= 1'b0;
          upd_r   <= 1'b0;
        end
      endcase
    end
  end

  assign busy        = busy_r;
  assign cmd.load    = accept;
  assign cmd.compare = cmp_r;
  assign cmd.update  = upd_r;

endmodule

// ----- rtl/core/spq_dp.sv -----
// Datapath for the sorted priority queue: entry array, parallel compare,
// one-step shift and result registers. Depends on spq_pkg.
module spq_dp
  import spq_pkg::*;
#(
  parameter int DEPTH = SpqDepthDef
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_cmd_t                 cmd,
  input  logic [KindW-1:0]         in_kind,
  input  logic signed [ValueW-1:0] in_value,
  output logic                     out_strobe,
  output logic                     out_ok,
  output logic [PosW-1:0]          out_position,
  output logic [CountW-1:0]        out_entry_count,
  output logic                     out_head_valid,
  output logic signed [ValueW-1:0] out_head_value
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [KindW-1:0]         kind_r;
  logic signed [ValueW-1:0] value_r;
  logic [DEPTH-1:0]         lt_r;
  logic [DEPTH-1:0]         eq_r;
  logic signed [ValueW-1:0] ent_r   [DEPTH];
  logic signed [ValueW-1:0] ent_nxt [DEPTH];
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;

  logic                     strobe_r;
  logic                     ok_r;
  logic [PosW-1:0]          pos_r;
  logic [CountW-1:0]        ecount_r;
  logic                     hvalid_r;
  logic signed [ValueW-1:0] hvalue_r;

  logic [DEPTH-1:0]         lt_c;
  logic [DEPTH-1:0]         eq_c;
  logic [DEPTH-1:0]         ge_m;
  logic                     found;
  logic                     full;
  logic [IW-1:0]            pos_c;
  logic                     ok_nxt;
  logic [IW-1:0]            pos_nxt;
  logic                     hvalid_nxt;
  logic signed [ValueW-1:0] hvalue_nxt;

  // Compare the held value against every live entry
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt_c[i] = (CW'(i) < count_r) && (ent_r[i] < value_r);
      eq_c[i] = (CW'(i) < count_r) && (ent_r[i] == value_r);
    end
  end

  // Entries at or past the insertion point; live smaller entries form a prefix
  assign ge_m  = ~lt_r;
  assign found = |eq_r;
  assign full  = (count_r == CW'(DEPTH));

  // Locate the first entry that is not smaller
  always_comb begin
    pos_c = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (ge_m[i]) begin
        pos_c = IW'(i);
      end
    end
  end

  // Work out the shifted array and the result
  always_comb begin
    ent_nxt   = ent_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    pos_nxt   = '0;
    case (kind_r)
      KIND_INSERT: begin
        if (!full) begin
          if (ge_m[0]) begin
            ent_nxt[0] = value_r;
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (ge_m[i-1]) begin
              ent_nxt[i] = ent_r[i-1];
            end else if (ge_m[i]) begin
              ent_nxt[i] = value_r;
            end
          end
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
          pos_nxt   = pos_c;
        end
      end
      KIND_REMOVE: begin
        if (found) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (ge_m[i]) begin
              ent_nxt[i] = ent_r[i+1];
            end
          end
          count_nxt = count_r - CW'(1);
          ok_nxt    = 1'b1;
          pos_nxt   = pos_c;
        end
      end
      KIND_FIND: begin
        if (found) begin
          ok_nxt  = 1'b1;
          pos_nxt = pos_c;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  assign hvalid_nxt = (count_nxt != '0);
  assign hvalue_nxt = hvalid_nxt ? ent_nxt[0] : '0;

  // Payload registers: capture beat, compare vectors, entries, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    if (cmd.compare) begin
      lt_r <= lt_c;
      eq_r <= eq_c;
    end
    if (cmd.update) begin
      ent_r    <= ent_nxt;
      ok_r     <= ok_nxt;
      pos_r    <= PosW'(pos_nxt);
      ecount_r <= CountW'(count_nxt);
      hvalid_r <= hvalid_nxt;
      hvalue_r <= hvalue_nxt;
    end
  end

  // Control registers: entry count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.update;
      if (cmd.update) begin
        count_r <= count_nxt;
      end
    end
  end

  assign out_strobe      = strobe_r;
  assign out_ok          = ok_r;
  assign out_position    = pos_r;
  assign out_entry_count = ecount_r;
  assign out_head_valid  = hvalid_r;
  assign out_head_value  = hvalue_r;

endmodule
